/* rtl/yrh_pkg.sv */
// Package for the yaw rate block: widths, constants, action and register codes,
// the heading wrap function and the divider result type.
// No dependencies.
`default_nettype none

package yrh_pkg;

    // Angle scaling: 1/2^ANGLE_FRAC_BITS degree per count
    localparam int ANGLE_FRAC_BITS = 8;

    localparam int HEAD_W = 17;
    localparam int TIME_W = 32;
    localparam int RATE_W = 27;
    localparam int ACT_W  = 3;

    localparam int ALPHA_W = 16;
    localparam int DECAY_W = 16;
    localparam int STILL_W = 8;
    localparam int MING_W  = 10;
    localparam int MAXG_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 3;

    // Divider: |diff| * 1000 fits 26 bits, gap on the filter path fits 16 bits
    localparam int DVD_W = 26;
    localparam int DVS_W = 16;

    // Multiplier: signed 27 x unsigned 17 (as signed 18)
    localparam int MOP_W  = 17;
    localparam int PROD_W = RATE_W + MOP_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int Q16    = 16;

    localparam logic signed [18:0] FULL_TURN = 19'(360 * (2 ** ANGLE_FRAC_BITS));
    localparam logic signed [18:0] HALF_TURN = 19'(180 * (2 ** ANGLE_FRAC_BITS));

    localparam longint RATE_LIM_RAW = 64'd180000 * (64'd1 << ANGLE_FRAC_BITS);
    localparam longint RATE_CAP     = 64'd67108863;
    localparam longint RATE_LIM     = (RATE_LIM_RAW < RATE_CAP) ? RATE_LIM_RAW : RATE_CAP;
    localparam logic signed [RATE_W-1:0] RATE_LIM_27 = RATE_W'(RATE_LIM);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_FIRST = 3'd0;
    localparam logic [ACT_W-1:0] ACT_STILL = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SOON  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_GAP   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FILT  = 3'd4;

    // Register indexes
    localparam logic [CFG_A_W-1:0] REG_ALPHA = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_DECAY = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_STILL = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_MING  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_MAXG  = 3'd4;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quo;
        logic             rem_nz;
    } t_div_res;

    // Heading difference into [-180, 180); the raw 18-bit difference never
    // needs more than one turn added or removed.
    function automatic logic signed [HEAD_W-1:0] wrap_angle(input logic signed [17:0] d);
        logic signed [18:0] dx;
        logic signed [18:0] r;
        dx = {d[17], d};
        if (dx >= HALF_TURN) begin
            r = dx - FULL_TURN;
        end else if (dx < -HALF_TURN) begin
            r = dx + FULL_TURN;
        end else begin
            r = dx;
        end
        return r[HEAD_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/yrh_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on yrh_pkg.
`default_nettype none

module yrh_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [yrh_pkg::DVD_W-1:0] i_dvd,
    input  wire logic [yrh_pkg::DVS_W-1:0] i_dvs,
    output yrh_pkg::t_div_res              o_res
);
    import yrh_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DVS_W:0] sh;
    logic [DVS_W:0] trial;
    logic           qbit;

    always_comb begin
        sh    = {r_rem, r_quo[DVD_W-1]};
        trial = sh - {1'b0, r_dvs};
        qbit  = (sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DVD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DVD_W-2:0], qbit};
            r_rem <= qbit ? trial[DVS_W-1:0] : sh[DVS_W-1:0];
        end
    end

    assign o_res.done   = r_done;
    assign o_res.quo    = r_quo;
    assign o_res.rem_nz = (r_rem != '0);

endmodule

`default_nettype wire

/* rtl/yrh_mul.sv */
// Shared registered multiplier: signed rate operand times unsigned Q1.16 weight.
// Depends on yrh_pkg.
`default_nettype none

module yrh_mul (
    input  wire logic                              i_clk,
    input  wire logic signed [yrh_pkg::RATE_W-1:0] i_a,
    input  wire logic        [yrh_pkg::MOP_W-1:0]  i_b,
    output      logic signed [yrh_pkg::PROD_W-1:0] o_p
);
    import yrh_pkg::*;

    logic signed [MOP_W:0] b_s;

    assign b_s = {1'b0, i_b};

    always_ff @(posedge i_clk) begin
        o_p <= PROD_W'(i_a) * PROD_W'(b_s);
    end

endmodule

`default_nettype wire

/* rtl/yaw_rate_from_heading_core.sv */
// Yaw rate from timestamped heading: wrapped differentiator with Q0.16 low-pass.
// Path from request to result: first, too soon and gap reset go S_LOAD, S_CLASS, S_DONE;
// still decay adds S_DEC1 and S_DEC2; filtered adds the serial divider, S_RAW, S_MUL1-3, S_SAT.
// One request in flight; the next is taken once the result is registered and the state is back in S_IDLE.
// Reset (i_rst_n low, synchronous) clears state, output valid and sets register defaults.
// Depends on yrh_pkg, yrh_div, yrh_mul.
`default_nettype none

module yaw_rate_from_heading_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input request: tdata = heading[16:0], time_ms[31:0] from bit 0, zero filled
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,
    // result: tdata = yaw_rate[26:0], zero filled to 32
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,
    // result kind: tuser = action[2:0]
    output      logic [2:0]  m_axis_tuser,
    // register writes
    input  wire logic                         i_cfg_we,
    input  wire logic [yrh_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  wire logic [yrh_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import yrh_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;  // wrap difference, time gap
    localparam logic [3:0] S_CLASS = 4'd2;  // pick the case, start divider
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_RAW   = 4'd4;  // signed floor quotient
    localparam logic [3:0] S_MUL1  = 4'd5;  // alpha * raw
    localparam logic [3:0] S_MUL2  = 4'd6;  // (1 - alpha) * rate
    localparam logic [3:0] S_MUL3  = 4'd7;  // sum
    localparam logic [3:0] S_SAT   = 4'd8;  // shift, clamp, re-anchor
    localparam logic [3:0] S_DEC1  = 4'd9;  // rate * decay
    localparam logic [3:0] S_DEC2  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] r_state;

    // Registers
    logic [ALPHA_W-1:0] r_alpha;
    logic [DECAY_W-1:0] r_decay;
    logic [STILL_W-1:0] r_still;
    logic [MING_W-1:0]  r_min_gap;
    logic [MAXG_W-1:0]  r_max_gap;

    // Block state
    logic signed [HEAD_W-1:0] r_last_head;
    logic [TIME_W-1:0]        r_last_time;
    logic                     r_started;
    logic signed [RATE_W-1:0] r_rate;

    // Working registers
    logic signed [HEAD_W-1:0] r_head;
    logic [TIME_W-1:0]        r_time;
    logic signed [HEAD_W-1:0] r_diff;
    logic [TIME_W-1:0]        r_gap;
    logic signed [RATE_W-1:0] r_raw;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ACT_W-1:0]         r_act;

    // Output register
    logic                     r_out_valid;
    logic [RATE_W-1:0]        r_out_rate;
    logic [ACT_W-1:0]         r_out_act;

    // Datapath
    logic                     in_acc;
    logic [HEAD_W-2:0]        mag;
    logic [DVD_W-1:0]         dvd;
    logic                     is_still;
    logic                     is_soon;
    logic                     is_long;
    logic signed [RATE_W-1:0] mul_a;
    logic [MOP_W-1:0]         mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-Q16-1:0] acc_sh;
    logic [DVD_W-1:0]         q_adj;
    t_div_res                 div_res;
    logic                     div_start;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_rate};
    assign m_axis_tuser  = r_out_act;

    // Case selection on the registered difference and gap
    always_comb begin
        mag      = r_diff[HEAD_W-1] ? (HEAD_W-1)'(-r_diff) : r_diff[HEAD_W-2:0];
        dvd      = DVD_W'(mag) * DVD_W'(1000);
        is_still = ({1'b0, mag} < HEAD_W'(r_still));
        is_soon  = (r_gap < TIME_W'(r_min_gap)) || (r_gap == '0);
        is_long  = (r_gap > TIME_W'(r_max_gap));
    end

    assign div_start = (r_state == S_CLASS) && r_started && !is_still && !is_soon && !is_long;

    yrh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (dvd),
        .i_dvs   (r_gap[DVS_W-1:0]),
        .o_res   (div_res)
    );

    // Multiplier operand select by step
    always_comb begin
        unique case (r_state)
            S_MUL1: begin
                mul_a = r_raw;
                mul_b = MOP_W'(r_alpha);
            end
            S_MUL2: begin
                mul_a = r_rate;
                mul_b = MOP_W'(1 << Q16) - MOP_W'(r_alpha);
            end
            default: begin
                mul_a = r_rate;
                mul_b = MOP_W'(r_decay);
            end
        endcase
    end

    yrh_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign acc_sh = r_acc[ACC_W-1:Q16];
    // floor toward minus infinity for a negative dividend
    assign q_adj  = div_res.quo + DVD_W'(div_res.rem_nz);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= ALPHA_W'(19661);
            r_decay   <= DECAY_W'(62259);
            r_still   <= STILL_W'(1);
            r_min_gap <= MING_W'(1);
            r_max_gap <= MAXG_W'(500);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ALPHA: r_alpha   <= i_cfg_wdata[ALPHA_W-1:0];
                REG_DECAY: r_decay   <= i_cfg_wdata[DECAY_W-1:0];
                REG_STILL: r_still   <= i_cfg_wdata[STILL_W-1:0];
                REG_MING:  r_min_gap <= i_cfg_wdata[MING_W-1:0];
                REG_MAXG:  r_max_gap <= i_cfg_wdata[MAXG_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_last_head <= '0;
            r_last_time <= '0;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (r_out_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_CLASS;
                end
                S_CLASS: begin
                    if (!r_started) begin
                        r_last_head <= r_head;
                        r_last_time <= r_time;
                        r_started   <= 1'b1;
                        r_rate      <= '0;
                        r_state     <= S_DONE;
                    end else if (is_still) begin
                        r_state <= S_DEC1;
                    end else if (is_soon) begin
                        r_state <= S_DONE;
                    end else if (is_long) begin
                        r_last_head <= r_head;
                        r_last_time <= r_time;
                        r_rate      <= '0;
                        r_state     <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_res.done) begin
                        r_state <= S_RAW;
                    end
                end
                S_RAW:  r_state <= S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_MUL3;
                S_MUL3: r_state <= S_SAT;
                S_SAT: begin
                    if (acc_sh > (ACC_W-Q16)'(RATE_LIM_27)) begin
                        r_rate <= RATE_LIM_27;
                    end else if (acc_sh < -(ACC_W-Q16)'(RATE_LIM_27)) begin
                        r_rate <= -RATE_LIM_27;
                    end else begin
                        r_rate <= acc_sh[RATE_W-1:0];
                    end
                    r_last_head <= r_head;
                    r_last_time <= r_time;
                    r_state     <= S_DONE;
                end
                S_DEC1: r_state <= S_DEC2;
                S_DEC2: begin
                    r_rate  <= prod[RATE_W+Q16-1:Q16];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_head <= s_axis_tdata[HEAD_W-1:0];
            r_time <= s_axis_tdata[HEAD_W+TIME_W-1:HEAD_W];
        end
        if (r_state == S_LOAD) begin
            r_diff <= wrap_angle({r_head[HEAD_W-1], r_head} - {r_last_head[HEAD_W-1], r_last_head});
            r_gap  <= r_time - r_last_time;
        end
        if (r_state == S_CLASS) begin
            if (!r_started) begin
                r_act <= ACT_FIRST;
            end else if (is_still) begin
                r_act <= ACT_STILL;
            end else if (is_soon) begin
                r_act <= ACT_SOON;
            end else if (is_long) begin
                r_act <= ACT_GAP;
            end else begin
                r_act <= ACT_FILT;
            end
        end
        if (r_state == S_RAW) begin
            r_raw <= r_diff[HEAD_W-1] ? -$signed({1'b0, q_adj}) : $signed({1'b0, div_res.quo});
        end
        if (r_state == S_MUL2) begin
            r_acc <= ACC_W'(prod);
        end
        if (r_state == S_MUL3) begin
            r_acc <= r_acc + ACC_W'(prod);
        end
        if ((r_state == S_DONE) && (!r_out_valid || m_axis_tready)) begin
            r_out_rate <= r_rate;
            r_out_act  <= r_act;
        end
    end

endmodule

`default_nettype wire

/* rtl/yrh_checker.sv */
// Port-level checks for the yaw rate core, attached by bind.
// Depends on yrh_pkg and yaw_rate_from_heading_core.
`default_nettype none

module yrh_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);
    import yrh_pkg::*;

    // one request in flight: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("core took a second request while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[26:0]) <= RATE_LIM_27
            && $signed(m_axis_tdata[26:0]) >= -RATE_LIM_27))
        else $error("yaw rate outside saturation limit");

    a_anchor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ACT_FIRST || m_axis_tuser == ACT_GAP))
            |-> (m_axis_tdata[26:0] == 27'd0))
        else $error("re-anchor result carries nonzero rate");

endmodule

bind yaw_rate_from_heading_core yrh_checker u_yrh_checker (.*);

`default_nettype wire
